// ===== rtl/dltq_pkg.sv =====
`default_nettype none
package dltq_pkg;

  localparam int unsigned TimeBits = 32;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_ADD     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_FIRED  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_ADD,
    ST_CHK,
    ST_WALK,
    ST_FIRE,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                 operation;
    logic [TimeBits-1:0] ticks;
    logic [15:0]         tag;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] fired_tag;
    logic [4:0]  fired_count;
    logic        last;
  } out_item_t;

  // Insert token walking down the chain (tag travels beside it)
  typedef struct packed {
    logic                vld;
    logic                shifting;
    logic [TimeBits-1:0] delta;
  } tok_t;

  typedef struct packed {
    logic                pop;
    logic                sub_en;
    logic [TimeBits-1:0] sub_val;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/dltq_cell.sv =====
`default_nettype none
module dltq_cell
  import dltq_pkg::*;
#(
  parameter int unsigned TAG_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cell_ctl_t           ctl_i,
  input  wire tok_t                tok_i,
  input  wire logic [TAG_BITS-1:0] tok_tag_i,
  input  wire logic                nxt_vld_i,
  input  wire logic [TimeBits-1:0] nxt_delta_i,
  input  wire logic [TAG_BITS-1:0] nxt_tag_i,
  output logic                     vld_o,
  output logic [TimeBits-1:0]      delta_o,
  output logic [TAG_BITS-1:0]      tag_o,
  output tok_t                     tok_o,
  output logic [TAG_BITS-1:0]      tok_tag_o,
  output logic                     absorb_o
);

  logic                vld_q, vld_d;
  logic [TimeBits-1:0] delta_q, delta_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  tok_t                tok_q, tok_d;
  logic [TAG_BITS-1:0] tok_tag_q, tok_tag_d;

  always_comb begin
    vld_d     = vld_q;
    delta_d   = delta_q;
    tag_d     = tag_q;
    tok_d     = '0;
    tok_tag_d = tok_tag_q;
    if (ctl_i.pop) begin
      vld_d   = nxt_vld_i;
      delta_d = nxt_delta_i;
      tag_d   = nxt_tag_i;
    end else if (ctl_i.sub_en) begin
      delta_d = delta_q - ctl_i.sub_val;
    end else if (tok_i.vld) begin
      if (!vld_q) begin
        vld_d   = 1'b1;
        delta_d = tok_i.delta;
        tag_d   = tok_tag_i;
      end else if (tok_i.shifting) begin
        // ripple the displaced entry down unchanged
        delta_d   = tok_i.delta;
        tag_d     = tok_tag_i;
        tok_d     = '{vld: 1'b1, shifting: 1'b1, delta: delta_q};
        tok_tag_d = tag_q;
      end else if (tok_i.delta < delta_q) begin
        // new entry lands here; successor keeps only the remainder
        delta_d   = tok_i.delta;
        tag_d     = tok_tag_i;
        tok_d     = '{vld: 1'b1, shifting: 1'b1, delta: delta_q - tok_i.delta};
        tok_tag_d = tag_q;
      end else begin
        tok_d     = '{vld: 1'b1, shifting: 1'b0, delta: tok_i.delta - delta_q};
        tok_tag_d = tok_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      vld_q <= vld_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q   <= delta_d;
    tag_q     <= tag_d;
    tok_tag_q <= tok_tag_d;
  end

  assign vld_o     = vld_q;
  assign delta_o   = delta_q;
  assign tag_o     = tag_q;
  assign tok_o     = tok_q;
  assign tok_tag_o = tok_tag_q;
  assign absorb_o  = tok_i.vld & ~vld_q & ~ctl_i.pop & ~ctl_i.sub_en;

endmodule
`default_nettype wire

// ===== rtl/delta_list_timer_queue.sv =====
`default_nettype none
// Channel | Dir | Handshake               | Payload
// input   | in  | in_valid_i / in_stall_o  | in_data_i  (operation, ticks, tag)
// output  | out | out_valid_o / out_stall_i| out_data_o (kind, fired_tag, fired_count, last)
//
// One item at a time. Advance: fired timers leave the head cell one per cycle
// while the output is not stalled. Add: the insert token steps one cell per cycle
// down the chain until an empty cell absorbs it.
// The sequencer returns to idle after each item before the next one is taken.
// Reset clears the queue and slack at once; no clearing pass.
// A stalled output holds the sequencer; a new item is taken while the final
// result of the previous one still waits in the output register.
module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  state_e              state_q, state_d;
  logic [TimeBits-1:0] t_q, t_d;
  logic [TAG_BITS-1:0] tag_q;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                had_q;
  logic [TimeBits-1:0] slack_q, slack_d;

  logic                out_vld_q;
  out_item_t           out_q;
  logic                out_free;

  logic                emit;
  out_item_t           emit_data;

  logic                pop, sub_en;
  tok_t                inj_tok;
  logic                in_acc;

  logic [QUEUE_DEPTH-1:0] cell_vld;
  logic [TimeBits-1:0]    cell_delta [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    cell_tag   [QUEUE_DEPTH];
  tok_t                   tok        [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    tok_tag    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] tok_vld;
  logic [QUEUE_DEPTH-1:0] absorb;
  logic                   absorb_any;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      cell_ctl_t           ctl;
      tok_t                tin;
      logic [TAG_BITS-1:0] tin_tag;
      logic                nvld;
      logic [TimeBits-1:0] ndelta;
      logic [TAG_BITS-1:0] ntag;

      if (gi == 0) begin : g_head
        assign tin     = inj_tok;
        assign tin_tag = tag_q;
        assign ctl     = '{pop: pop, sub_en: sub_en, sub_val: t_q};
      end else begin : g_body
        assign tin     = tok[gi-1];
        assign tin_tag = tok_tag[gi-1];
        assign ctl     = '{pop: pop, sub_en: 1'b0, sub_val: t_q};
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign nvld   = 1'b0;
        assign ndelta = '0;
        assign ntag   = '0;
      end else begin : g_link
        assign nvld   = cell_vld[gi+1];
        assign ndelta = cell_delta[gi+1];
        assign ntag   = cell_tag[gi+1];
      end

      dltq_cell #(
        .TAG_BITS(TAG_BITS)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .tok_i      (tin),
        .tok_tag_i  (tin_tag),
        .nxt_vld_i  (nvld),
        .nxt_delta_i(ndelta),
        .nxt_tag_i  (ntag),
        .vld_o      (cell_vld[gi]),
        .delta_o    (cell_delta[gi]),
        .tag_o      (cell_tag[gi]),
        .tok_o      (tok[gi]),
        .tok_tag_o  (tok_tag[gi]),
        .absorb_o   (absorb[gi])
      );

      assign tok_vld[gi] = tok[gi].vld;
    end
  endgenerate

  assign absorb_any = |absorb;
  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d   = state_q;
    t_d       = t_q;
    cnt_d     = cnt_q;
    slack_d   = slack_q;
    emit      = 1'b0;
    emit_data = '{kind: KIND_DONE, fired_tag: '0, fired_count: '0, last: 1'b1};
    pop       = 1'b0;
    sub_en    = 1'b0;
    inj_tok   = '{vld: 1'b0, shifting: 1'b0, delta: t_q};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          t_d     = in_data_i.ticks;
          cnt_d   = '0;
          state_d = (in_data_i.operation == OP_ADD) ? ST_ADD : ST_ADV;
        end
      end
      ST_ADV: begin
        if (cell_vld[0] && (t_q >= cell_delta[0])) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_data = '{kind: KIND_FIRED, fired_tag: 16'(cell_tag[0]),
                          fired_count: '0, last: 1'b0};
            pop       = 1'b1;
            t_d       = t_q - cell_delta[0];
            cnt_d     = cnt_q + CntBits'(1);
          end
        end else begin
          if (cell_vld[0]) begin
            sub_en = 1'b1;
          end else if (had_q) begin
            slack_d = t_q;
          end
          state_d = ST_DONE;
        end
      end
      ST_ADD: begin
        if (t_q == '0) begin
          state_d = ST_FIRE;
        end else if (!cell_vld[0]) begin
          if (t_q <= slack_q) begin
            slack_d = slack_q - t_q;
            state_d = ST_FIRE;
          end else begin
            t_d     = t_q - slack_q;
            slack_d = '0;
            state_d = ST_CHK;
          end
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (cell_vld[QUEUE_DEPTH-1]) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_data = '{kind: KIND_REJECT, fired_tag: '0, fired_count: '0,
                          last: 1'b1};
            state_d   = ST_IDLE;
          end
        end else begin
          inj_tok.vld = 1'b1;
          state_d     = absorb_any ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (absorb_any) begin
          state_d = ST_DONE;
        end
      end
      ST_FIRE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{kind: KIND_FIRED, fired_tag: 16'(tag_q),
                        fired_count: '0, last: 1'b0};
          cnt_d     = CntBits'(1);
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{kind: KIND_DONE, fired_tag: '0,
                        fired_count: 5'(cnt_q), last: 1'b1};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slack_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slack_q <= slack_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    cnt_q <= cnt_d;
    if (in_acc) begin
      tag_q <= TAG_BITS'(in_data_i.tag);
      had_q <= cell_vld[0];
    end
    if (emit) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // occupied cells form a prefix of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((cell_vld >> 1) & ~cell_vld) == '0))
    else $error("queue cells not contiguous");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one insert token in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tok_vld == '0))
    else $error("insert token alive while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slack_q != '0) |-> !cell_vld[0])
    else $error("slack kept while queue holds entries");

endmodule
`default_nettype wire

// ===== dv/delta_list_timer_queue_tb.sv =====
`default_nettype none
module delta_list_timer_queue_tb;
  import dltq_pkg::*;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned LimitCycles = 300000;
  localparam int unsigned RandomItems = 140;
  localparam int unsigned HoldCycles  = 400;

  typedef struct {
    in_item_t item;
    bit       drain;  // wait for every pending result before offering this one
  } stim_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  delta_list_timer_queue #(
    .QUEUE_DEPTH(QueueDepth),
    .TAG_BITS   (16)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stim_t       item_q[$];
  out_item_t   fire_q[$];
  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned hold_at = 0;
  int unsigned cycle_cnt = 0;

  // Shadow copy of the timer list
  logic [31:0] tq_delta[QueueDepth];
  logic [15:0] tq_tag[QueueDepth];
  int unsigned tq_count = 0;
  logic [31:0] tq_slack = '0;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("mismatch @%0d: %s", cycle_cnt, msg);
  endtask

  task automatic push_fire(input kind_e kind, input logic [15:0] tag,
                           input logic [4:0] cnt, input logic last);
    out_item_t r;
    r.kind        = kind;
    r.fired_tag   = tag;
    r.fired_count = cnt;
    r.last        = last;
    fire_q.insert(fire_q.size(), r);
  endtask

  task automatic add_item(input op_e op, input logic [31:0] ticks,
                          input logic [15:0] tag, input bit drain);
    stim_t s;
    s.item.operation = op;
    s.item.ticks     = ticks;
    s.item.tag       = tag;
    s.drain          = drain;
    item_q.insert(item_q.size(), s);
  endtask

  // Apply one accepted transaction to the shadow list and queue its results
  task automatic timer_list_step(input in_item_t it);
    logic [31:0] t;
    logic [4:0]  fired;
    int unsigned pos;
    t     = it.ticks;
    fired = '0;
    if (it.operation == OP_ADVANCE) begin
      if (tq_count > 0) begin
        while (tq_count > 0 && t >= tq_delta[0]) begin
          t -= tq_delta[0];
          push_fire(KIND_FIRED, tq_tag[0], '0, 1'b0);
          fired++;
          for (int i = 1; i < tq_count; i++) begin
            tq_delta[i-1] = tq_delta[i];
            tq_tag[i-1]   = tq_tag[i];
          end
          tq_count--;
        end
        if (tq_count == 0) tq_slack = t;
        else tq_delta[0] -= t;
      end
      push_fire(KIND_DONE, '0, fired, 1'b1);
      return;
    end
    if (t == '0) begin
      push_fire(KIND_FIRED, it.tag, '0, 1'b0);
      push_fire(KIND_DONE, '0, 5'd1, 1'b1);
      return;
    end
    if (tq_count == 0) begin
      if (t <= tq_slack) begin
        tq_slack -= t;
        push_fire(KIND_FIRED, it.tag, '0, 1'b0);
        push_fire(KIND_DONE, '0, 5'd1, 1'b1);
        return;
      end
      t -= tq_slack;
      tq_slack = '0;
    end
    if (tq_count >= QueueDepth) begin
      push_fire(KIND_REJECT, '0, '0, 1'b1);
      return;
    end
    for (pos = 0; pos < tq_count; pos++) begin
      if (t < tq_delta[pos]) begin
        tq_delta[pos] -= t;
        break;
      end
      t -= tq_delta[pos];
    end
    for (int i = tq_count; i > pos; i--) begin
      tq_delta[i] = tq_delta[i-1];
      tq_tag[i]   = tq_tag[i-1];
    end
    tq_delta[pos] = t;
    tq_tag[pos]   = it.tag;
    tq_count++;
    push_fire(KIND_DONE, '0, '0, 1'b1);
  endtask

  // Driver: bursts of random length separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        timer_list_step(in_data_i);
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (item_q.size() > 0 && (!item_q[0].drain || fire_q.size() == 0)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= item_q[0].item;
          item_q.delete(0);
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_pct = 0;
  int unsigned mode_left = 0;

  always @(posedge clk_i) begin : recv
    out_item_t expd;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (fire_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction kind=%0d tag=%h cnt=%0d last=%0b",
                                    out_data_o.kind, out_data_o.fired_tag,
                                    out_data_o.fired_count, out_data_o.last));
        end else begin
          expd = fire_q[0];
          fire_q.delete(0);
          if (out_data_o.kind != expd.kind)
            report_mismatch($sformatf("kind got %0d exp %0d", out_data_o.kind, expd.kind));
          if (out_data_o.fired_tag != expd.fired_tag)
            report_mismatch($sformatf("fired_tag got %h exp %h",
                                      out_data_o.fired_tag, expd.fired_tag));
          if (out_data_o.fired_count != expd.fired_count)
            report_mismatch($sformatf("fired_count got %0d exp %0d",
                                      out_data_o.fired_count, expd.fired_count));
          if (out_data_o.last != expd.last)
            report_mismatch($sformatf("last got %0b exp %0b", out_data_o.last, expd.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && hold_at != 0 && n_sent >= hold_at) begin
        // long back-pressure so the block fills up and stalls its input
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end else begin
          mode_left--;
        end
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned add_pct;
    int unsigned r;
    op_e         op;
    logic [31:0] ticks;

    // empty queue, then slack handling
    add_item(OP_ADVANCE, 32'd0, 16'h0000, 1'b0);
    add_item(OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    add_item(OP_ADD, 32'd0, 16'hFFFF, 1'b0);
    add_item(OP_ADD, 32'd100, 16'h0001, 1'b0);
    add_item(OP_ADVANCE, 32'd250, 16'hFFFF, 1'b0);     // empties, leaves slack
    add_item(OP_ADD, 32'd90, 16'h0002, 1'b0);          // inside slack
    add_item(OP_ADD, 32'd60, 16'h0003, 1'b0);          // uses slack exactly
    add_item(OP_ADD, 32'd50, 16'h0004, 1'b0);
    add_item(OP_ADVANCE, 32'd80, 16'h0000, 1'b0);
    add_item(OP_ADD, 32'd100, 16'h0005, 1'b0);         // beyond slack
    add_item(OP_ADD, 32'd70, 16'h0006, 1'b0);          // equal time, goes after
    add_item(OP_ADD, 32'd30, 16'h0007, 1'b0);          // goes in front
    add_item(OP_ADD, 32'hFFFF_FFFF, 16'hAAAA, 1'b0);
    add_item(OP_ADVANCE, 32'd10, 16'h0000, 1'b0);      // leaves entries
    for (int k = 0; k < 12; k++)
      add_item(OP_ADD, 32'd5 + k * 37,
               (k % 2) ? 16'(16'h5555 ^ k) : 16'(16'hFFFF ^ k), 1'b0);
    add_item(OP_ADD, 32'd5, 16'h1234, 1'b0);           // full: rejected
    add_item(OP_ADD, 32'd0, 16'h4321, 1'b0);           // zero delay while full
    add_item(OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000, 1'b0); // fires all sixteen
    hold_at = item_q.size() + 50;

    add_pct = 55;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 30;
          1: add_pct = 55;
          default: add_pct = 85;
        endcase
      end
      op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_ADVANCE;
      r  = $urandom_range(0, 99);
      if (op == OP_ADD)
        ticks = (r < 10) ? 32'd0 : (r < 75) ? $urandom_range(1, 200) :
                (r < 90) ? $urandom : $urandom_range(1, 20);
      else
        ticks = (r < 80) ? $urandom_range(0, 150) :
                (r < 92) ? $urandom_range(150, 3000) : $urandom;
      add_item(op, ticks, 16'($urandom_range(0, 16'hFFFF)), (i == 0) || (i == 110));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (fire_q.size() != 0) @(posedge clk_i);
    repeat (QueueDepth + 24) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/dltq_pkg.sv
rtl/dltq_cell.sv
rtl/delta_list_timer_queue.sv
dv/delta_list_timer_queue_tb.sv
